FILE: hw/rtl/ges_pkg.sv
// ----------------------------------------------------------------------------
// ges_pkg
// Shared types and constants of the Gaussian elimination solver: command and
// result words, controller and float unit states, float unit request/response.
// ----------------------------------------------------------------------------
package ges_pkg;

  localparam int MAX_SIZE_DEF = 16;
  localparam int SIZE_W       = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] OP_LOAD_RHS    = 2'd1;
  localparam logic [1:0] OP_SOLVE       = 2'd2;

  localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [31:0] element_value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  solution_index;
    logic [31:0] solution_value;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_NORM,
    FS_EXEC,
    FS_ALIGN,
    FS_DIVL,
    FS_POST,
    FS_ROUND,
    FS_DONE
  } fpu_state_t;

  typedef enum logic [4:0] {
    CS_IDLE,
    CS_FC0,
    CS_FC1,
    CS_FC2,
    CS_FC3,
    CS_FB0,
    CS_FB1,
    CS_FB2,
    CS_FB3,
    CS_FB4,
    CS_FK0,
    CS_FK1,
    CS_FK2,
    CS_FK3,
    CS_FK4,
    CS_B0,
    CS_B1,
    CS_B2,
    CS_BJ0,
    CS_BJ1,
    CS_BJ2,
    CS_BJ3,
    CS_BJ4,
    CS_BJ5,
    CS_BJ6,
    CS_BW,
    CS_O0,
    CS_O1
  } ctl_state_t;

endpackage

FILE: hw/rtl/ges_ram.sv
// ----------------------------------------------------------------------------
// ges_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ges_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ges_fpu.sv
// ----------------------------------------------------------------------------
// ges_fpu
// Multi-cycle binary32 subtract, multiply and divide unit, round to nearest
// even, with subnormals, one normalization bit and one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ges_fpu (
  input  logic              clk,
  input  logic              rst,
  input  ges_pkg::fpu_req_t req,
  output ges_pkg::fpu_rsp_t rsp
);

  ges_pkg::fpu_state_t state, state_next;
  ges_pkg::fop_t       op;

  logic               sa, sb, sr, sticky, sub;
  logic signed [10:0] ea, eb, e;
  logic [23:0]        ma, mb;
  logic [27:0]        m;
  logic [24:0]        rem;
  logic [25:0]        q;
  logic [4:0]         cnt;
  logic [31:0]        res;

  // operand decode
  logic [31:0] b_eff;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
  logic        spec_hit;
  logic [31:0] spec_val;

  always_comb begin
    b_eff  = (req.op == ges_pkg::FOP_SUB) ? {~req.b[31], req.b[30:0]} : req.b;
    a_nan  = (req.a[30:23] == 8'hFF) && (req.a[22:0] != 23'd0);
    b_nan  = (req.b[30:23] == 8'hFF) && (req.b[22:0] != 23'd0);
    a_inf  = (req.a[30:23] == 8'hFF) && (req.a[22:0] == 23'd0);
    b_inf  = (req.b[30:23] == 8'hFF) && (req.b[22:0] == 23'd0);
    a_zero = (req.a[30:0] == 31'd0);
    b_zero = (req.b[30:0] == 31'd0);
    sx     = req.a[31] ^ req.b[31];
    spec_hit = 1'b1;
    spec_val = 32'd0;
    if (a_nan) begin
      spec_val = {req.a[31], 8'hFF, 1'b1, req.a[21:0]};
    end else if (b_nan) begin
      spec_val = {req.b[31], 8'hFF, 1'b1, req.b[21:0]};
    end else begin
      unique case (req.op)
        ges_pkg::FOP_SUB: begin
          if (a_inf && b_inf) begin
            spec_val = (req.a[31] != b_eff[31]) ? ges_pkg::FP_DEFAULT_NAN
                                                : {req.a[31], 8'hFF, 23'd0};
          end else if (a_inf) begin
            spec_val = {req.a[31], 8'hFF, 23'd0};
          end else if (b_inf) begin
            spec_val = {b_eff[31], 8'hFF, 23'd0};
          end else if (a_zero && b_zero) begin
            spec_val = {req.a[31] & b_eff[31], 31'd0};
          end else if (a_zero) begin
            spec_val = b_eff;
          end else if (b_zero) begin
            spec_val = req.a;
          end else begin
            spec_hit = 1'b0;
          end
        end
        ges_pkg::FOP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_val = ges_pkg::FP_DEFAULT_NAN;
          end else if (a_inf || b_inf) begin
            spec_val = {sx, 8'hFF, 23'd0};
          end else if (a_zero || b_zero) begin
            spec_val = {sx, 31'd0};
          end else begin
            spec_hit = 1'b0;
          end
        end
        ges_pkg::FOP_DIV: begin
          if ((a_inf && b_inf) || (a_zero && b_zero)) begin
            spec_val = ges_pkg::FP_DEFAULT_NAN;
          end else if (a_inf || b_zero) begin
            spec_val = {sx, 8'hFF, 23'd0};
          end else if (b_inf || a_zero) begin
            spec_val = {sx, 31'd0};
          end else begin
            spec_hit = 1'b0;
          end
        end
        default: begin
          spec_hit = 1'b0;
        end
      endcase
    end
  end

  // add path
  logic               a_big;
  logic signed [10:0] d;
  logic [4:0]         dd;
  logic [27:0]        big_m, small_m, small_sh, small_al, sum;
  logic               lost;

  always_comb begin
    a_big    = (ea > eb) || ((ea == eb) && (ma >= mb));
    d        = ea - eb;
    dd       = (d > 11'sd27) ? 5'd28 : d[4:0];
    big_m    = {1'b0, ma, 3'b000};
    small_m  = {1'b0, mb, 3'b000};
    small_sh = small_m >> dd;
    lost     = |(small_m & ~(28'hFFF_FFFF << dd));
    small_al = {small_sh[27:1], small_sh[0] | lost};
    sum      = sub ? (big_m - small_al) : (big_m + small_al);
  end

  // multiply, divide step, rounding
  logic [47:0]        prod;
  logic               qbit;
  logic [24:0]        rem_n;
  logic               rnd_up;
  logic [24:0]        mr;
  logic signed [10:0] expf;

  always_comb begin
    prod   = ma * mb;
    qbit   = (rem >= {1'b0, mb});
    rem_n  = qbit ? (rem - {1'b0, mb}) : rem;
    rnd_up = m[2] & (m[1] | m[0] | sticky | m[3]);
    mr     = {1'b0, m[26:3]} + {24'd0, rnd_up};
    if (mr[24]) begin
      expf = e + 11'sd1;
    end else if (mr[23]) begin
      expf = e;
    end else begin
      expf = 11'sd0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ges_pkg::FS_IDLE:  if (req.start) state_next = spec_hit ? ges_pkg::FS_DONE
                                                              : ges_pkg::FS_NORM;
      ges_pkg::FS_NORM:  if (ma[23] && mb[23]) state_next = ges_pkg::FS_EXEC;
      ges_pkg::FS_EXEC: begin
        unique case (op)
          ges_pkg::FOP_MUL: state_next = ges_pkg::FS_POST;
          ges_pkg::FOP_DIV: state_next = ges_pkg::FS_DIVL;
          default:          state_next = ges_pkg::FS_ALIGN;
        endcase
      end
      ges_pkg::FS_ALIGN: state_next = (sum == 28'd0) ? ges_pkg::FS_DONE : ges_pkg::FS_POST;
      ges_pkg::FS_DIVL:  if (cnt == 5'd26) state_next = ges_pkg::FS_POST;
      ges_pkg::FS_POST: begin
        if (!m[27] && !(!m[26] && (e > 11'sd1)) && !(e < 11'sd1)) begin
          state_next = ges_pkg::FS_ROUND;
        end
      end
      ges_pkg::FS_ROUND: state_next = ges_pkg::FS_DONE;
      ges_pkg::FS_DONE:  state_next = ges_pkg::FS_IDLE;
      default:           state_next = ges_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    rsp.done   = (state == ges_pkg::FS_DONE);
    rsp.result = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ges_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ges_pkg::FS_IDLE: begin
        op  <= req.op;
        res <= spec_val;
        sa  <= req.a[31];
        sb  <= b_eff[31];
        ea  <= (req.a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, req.a[30:23]});
        eb  <= (req.b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, req.b[30:23]});
        ma  <= {req.a[30:23] != 8'd0, req.a[22:0]};
        mb  <= {req.b[30:23] != 8'd0, req.b[22:0]};
      end
      ges_pkg::FS_NORM: begin
        if (!ma[23]) begin
          ma <= {ma[22:0], 1'b0};
          ea <= ea - 11'sd1;
        end else if (!mb[23]) begin
          mb <= {mb[22:0], 1'b0};
          eb <= eb - 11'sd1;
        end
      end
      ges_pkg::FS_EXEC: begin
        sr  <= sa ^ sb;
        sub <= sa ^ sb;
        unique case (op)
          ges_pkg::FOP_MUL: begin
            m      <= prod[47:20];
            sticky <= |prod[19:0];
            e      <= ea + eb - 11'sd127;
          end
          ges_pkg::FOP_DIV: begin
            sticky <= 1'b0;
            rem    <= {1'b0, ma};
            q      <= '0;
            cnt    <= 5'd0;
            e      <= ea - eb + 11'sd127;
          end
          default: begin
            sticky <= 1'b0;
            if (!a_big) begin
              ma <= mb;
              mb <= ma;
              ea <= eb;
              eb <= ea;
              sa <= sb;
              sb <= sa;
            end
          end
        endcase
      end
      ges_pkg::FS_ALIGN: begin
        m   <= sum;
        e   <= ea;
        sr  <= sa;
        res <= 32'd0;
      end
      ges_pkg::FS_DIVL: begin
        rem <= {rem_n[23:0], 1'b0};
        q   <= {q[24:0], qbit};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd26) begin
          m      <= {1'b0, q, qbit};
          sticky <= (rem_n != 25'd0);
        end
      end
      ges_pkg::FS_POST: begin
        if (m[27]) begin
          m      <= {1'b0, m[27:1]};
          sticky <= sticky | m[0];
          e      <= e + 11'sd1;
        end else if (!m[26] && (e > 11'sd1)) begin
          m <= {m[26:0], 1'b0};
          e <= e - 11'sd1;
        end else if (e < -11'sd27) begin
          m      <= 28'd0;
          sticky <= sticky | (|m);
          e      <= 11'sd1;
        end else if (e < 11'sd1) begin
          m      <= {1'b0, m[27:1]};
          sticky <= sticky | m[0];
          e      <= e + 11'sd1;
        end
      end
      ges_pkg::FS_ROUND: begin
        if (expf >= 11'sd255) begin
          res <= {sr, 8'hFF, 23'd0};
        end else begin
          res <= {sr, expf[7:0], mr[24] ? 23'd0 : mr[22:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/gauss_elimination_solver_core.sv
// ----------------------------------------------------------------------------
// gauss_elimination_solver_core
// Dense A x = b solver: forward elimination without pivoting, then back
// substitution, on one shared multi-cycle binary32 unit under a sequencer.
// Loads are accepted back to back while the core is not busy.
// A solve of size n holds busy through forward elimination, back
// substitution and the output of its n solution words, with every float
// operation run in turn on the shared unit; each word is read from the
// solution store in O0 and shown in O1, and results cannot be stalled.
// Synchronous reset clears control and sets system_size to 16; stores are
// undefined until loaded.
// ----------------------------------------------------------------------------
module gauss_elimination_solver_core #(
  parameter int MAX_SIZE = ges_pkg::MAX_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  ges_pkg::cmd_t                    cmd,
  output logic                             valid,
  output ges_pkg::res_t                    result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ges_pkg::SIZE_W-1:0]       cfg_data
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int CW = (IW > ges_pkg::SIZE_W) ? IW : ges_pkg::SIZE_W;
  localparam logic [ges_pkg::SIZE_W-1:0] NLIM =
    ges_pkg::SIZE_W'((MAX_SIZE < 16) ? MAX_SIZE : 16);

  ges_pkg::ctl_state_t state, state_next;

  logic [ges_pkg::SIZE_W-1:0] system_size, n, n_eff, nm1;
  logic [IW-1:0]              i, j, k;
  logic [31:0]                opa, coef, tmp, xacc, piv;

  logic              mat_we, mat_re, rhs_we, rhs_re, sol_we, sol_re;
  logic [AW-1:0]     mat_waddr, mat_raddr;
  logic [IW-1:0]     rhs_waddr, rhs_raddr, sol_raddr;
  logic [31:0]       mat_wdata, rhs_wdata, mat_q, rhs_q, sol_q;

  ges_pkg::fpu_req_t fpu_req;
  ges_pkg::fpu_rsp_t fpu_rsp;

  logic accept, load_a, load_b, solve_go;
  logic i_last, j_last, k_last, i_more, i_zero;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    maddr = AW'(int'(r) * MAX_SIZE + int'(c));
  endfunction

  always_comb begin
    accept   = start && !busy;
    load_a   = accept && (cmd.opcode == ges_pkg::OP_LOAD_MATRIX) &&
               (int'(cmd.row_index) < MAX_SIZE) && (int'(cmd.col_index) < MAX_SIZE);
    load_b   = accept && (cmd.opcode == ges_pkg::OP_LOAD_RHS) &&
               (int'(cmd.row_index) < MAX_SIZE);
    solve_go = accept && (cmd.opcode == ges_pkg::OP_SOLVE);
    if (system_size == '0) begin
      n_eff = ges_pkg::SIZE_W'(1);
    end else if (system_size > NLIM) begin
      n_eff = NLIM;
    end else begin
      n_eff = system_size;
    end
    nm1    = n - ges_pkg::SIZE_W'(1);
    i_last = (CW'(i) == CW'(nm1));
    j_last = (CW'(j) == CW'(nm1));
    k_last = (CW'(k) == CW'(nm1));
    i_more = ((CW'(i) + CW'(2)) < CW'(n));
    i_zero = (i == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ges_pkg::CS_IDLE: begin
        if (solve_go) begin
          state_next = (n_eff == ges_pkg::SIZE_W'(1)) ? ges_pkg::CS_B0 : ges_pkg::CS_FC0;
        end
      end
      ges_pkg::CS_FC0: state_next = ges_pkg::CS_FC1;
      ges_pkg::CS_FC1: state_next = ges_pkg::CS_FC2;
      ges_pkg::CS_FC2: state_next = ges_pkg::CS_FC3;
      ges_pkg::CS_FC3: if (fpu_rsp.done) state_next = ges_pkg::CS_FB0;
      ges_pkg::CS_FB0: state_next = ges_pkg::CS_FB1;
      ges_pkg::CS_FB1: state_next = ges_pkg::CS_FB2;
      ges_pkg::CS_FB2: if (fpu_rsp.done) state_next = ges_pkg::CS_FB3;
      ges_pkg::CS_FB3: state_next = ges_pkg::CS_FB4;
      ges_pkg::CS_FB4: if (fpu_rsp.done) state_next = ges_pkg::CS_FK0;
      ges_pkg::CS_FK0: state_next = ges_pkg::CS_FK1;
      ges_pkg::CS_FK1: state_next = ges_pkg::CS_FK2;
      ges_pkg::CS_FK2: if (fpu_rsp.done) state_next = ges_pkg::CS_FK3;
      ges_pkg::CS_FK3: state_next = ges_pkg::CS_FK4;
      ges_pkg::CS_FK4: begin
        if (fpu_rsp.done) begin
          if (!k_last) begin
            state_next = ges_pkg::CS_FK0;
          end else if (!j_last || i_more) begin
            state_next = ges_pkg::CS_FC0;
          end else begin
            state_next = ges_pkg::CS_B0;
          end
        end
      end
      ges_pkg::CS_B0:  state_next = ges_pkg::CS_B1;
      ges_pkg::CS_B1:  state_next = ges_pkg::CS_B2;
      ges_pkg::CS_B2:  if (fpu_rsp.done) state_next = i_last ? ges_pkg::CS_BW : ges_pkg::CS_BJ0;
      ges_pkg::CS_BJ0: state_next = ges_pkg::CS_BJ1;
      ges_pkg::CS_BJ1: state_next = ges_pkg::CS_BJ2;
      ges_pkg::CS_BJ2: if (fpu_rsp.done) state_next = ges_pkg::CS_BJ3;
      ges_pkg::CS_BJ3: state_next = ges_pkg::CS_BJ4;
      ges_pkg::CS_BJ4: if (fpu_rsp.done) state_next = ges_pkg::CS_BJ5;
      ges_pkg::CS_BJ5: state_next = ges_pkg::CS_BJ6;
      ges_pkg::CS_BJ6: if (fpu_rsp.done) state_next = j_last ? ges_pkg::CS_BW : ges_pkg::CS_BJ0;
      ges_pkg::CS_BW:  state_next = i_zero ? ges_pkg::CS_O0 : ges_pkg::CS_B0;
      ges_pkg::CS_O0:  state_next = ges_pkg::CS_O1;
      ges_pkg::CS_O1:  state_next = i_last ? ges_pkg::CS_IDLE : ges_pkg::CS_O0;
      default:         state_next = ges_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ges_pkg::CS_IDLE);
    cfg_ready = 1'b1;
    mat_re    = 1'b0;
    rhs_re    = 1'b0;
    sol_re    = 1'b0;
    mat_raddr = maddr(i, i);
    rhs_raddr = i;
    sol_raddr = j;
    mat_we    = load_a;
    mat_waddr = maddr(IW'(cmd.row_index), IW'(cmd.col_index));
    mat_wdata = cmd.element_value;
    rhs_we    = load_b;
    rhs_waddr = IW'(cmd.row_index);
    rhs_wdata = cmd.element_value;
    sol_we    = 1'b0;
    fpu_req   = '{start: 1'b0, op: ges_pkg::FOP_SUB, a: mat_q, b: tmp};
    valid     = 1'b0;
    unique case (state)
      ges_pkg::CS_FC0: begin
        mat_re    = 1'b1;
        mat_raddr = maddr(j, i);
      end
      ges_pkg::CS_FC1: mat_re = 1'b1;
      ges_pkg::CS_FC2: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_DIV, a: opa, b: mat_q};
      ges_pkg::CS_FB0: rhs_re = 1'b1;
      ges_pkg::CS_FB1: begin
        fpu_req   = '{start: 1'b1, op: ges_pkg::FOP_MUL, a: coef, b: rhs_q};
        rhs_re    = 1'b1;
        rhs_raddr = j;
      end
      ges_pkg::CS_FB3: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_SUB, a: rhs_q, b: tmp};
      ges_pkg::CS_FB4: begin
        rhs_we    = fpu_rsp.done;
        rhs_waddr = j;
        rhs_wdata = fpu_rsp.result;
      end
      ges_pkg::CS_FK0: begin
        mat_re    = 1'b1;
        mat_raddr = maddr(i, k);
      end
      ges_pkg::CS_FK1: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_MUL, a: coef, b: mat_q};
      ges_pkg::CS_FK2: begin
        mat_re    = fpu_rsp.done;
        mat_raddr = maddr(j, k);
      end
      ges_pkg::CS_FK3: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_SUB, a: mat_q, b: tmp};
      ges_pkg::CS_FK4: begin
        mat_we    = fpu_rsp.done;
        mat_waddr = maddr(j, k);
        mat_wdata = fpu_rsp.result;
      end
      ges_pkg::CS_B0: begin
        mat_re = 1'b1;
        rhs_re = 1'b1;
      end
      ges_pkg::CS_B1: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_DIV, a: rhs_q, b: mat_q};
      ges_pkg::CS_BJ0: begin
        mat_re    = 1'b1;
        mat_raddr = maddr(i, j);
        sol_re    = 1'b1;
      end
      ges_pkg::CS_BJ1: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_MUL, a: mat_q, b: sol_q};
      ges_pkg::CS_BJ3: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_DIV, a: tmp, b: piv};
      ges_pkg::CS_BJ5: fpu_req = '{start: 1'b1, op: ges_pkg::FOP_SUB, a: xacc, b: tmp};
      ges_pkg::CS_BW:  sol_we = 1'b1;
      ges_pkg::CS_O0: begin
        sol_re    = 1'b1;
        sol_raddr = i;
      end
      ges_pkg::CS_O1:  valid = 1'b1;
      default: begin
      end
    endcase
    result.solution_index = 4'(i);
    result.solution_value = sol_q;
    result.last           = i_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ges_pkg::CS_IDLE;
      system_size <= ges_pkg::SIZE_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        system_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ges_pkg::CS_IDLE: begin
        if (solve_go) begin
          n <= n_eff;
          i <= '0;
          j <= IW'(1);
          k <= '0;
        end
      end
      ges_pkg::CS_FC1: opa  <= mat_q;
      ges_pkg::CS_FC3: if (fpu_rsp.done) coef <= fpu_rsp.result;
      ges_pkg::CS_FB2: if (fpu_rsp.done) tmp <= fpu_rsp.result;
      ges_pkg::CS_FB4: k <= '0;
      ges_pkg::CS_FK2: if (fpu_rsp.done) tmp <= fpu_rsp.result;
      ges_pkg::CS_FK4: begin
        if (fpu_rsp.done) begin
          if (!k_last) begin
            k <= k + IW'(1);
          end else if (!j_last) begin
            j <= j + IW'(1);
          end else if (i_more) begin
            i <= i + IW'(1);
            j <= i + IW'(2);
          end else begin
            i <= IW'(nm1);
          end
        end
      end
      ges_pkg::CS_B1: piv <= mat_q;
      ges_pkg::CS_B2: begin
        if (fpu_rsp.done) begin
          xacc <= fpu_rsp.result;
          j    <= i + IW'(1);
        end
      end
      ges_pkg::CS_BJ2: if (fpu_rsp.done) tmp <= fpu_rsp.result;
      ges_pkg::CS_BJ4: if (fpu_rsp.done) tmp <= fpu_rsp.result;
      ges_pkg::CS_BJ6: begin
        if (fpu_rsp.done) begin
          xacc <= fpu_rsp.result;
          j    <= j + IW'(1);
        end
      end
      ges_pkg::CS_BW:  if (!i_zero) i <= i - IW'(1);
      ges_pkg::CS_O1:  if (!i_last) i <= i + IW'(1);
      default: begin
      end
    endcase
  end

  ges_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (fpu_req),
    .rsp (fpu_rsp)
  );

  ges_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .re    (mat_re),
    .raddr (mat_raddr),
    .rdata (mat_q)
  );

  ges_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_rhs (
    .clk   (clk),
    .we    (rhs_we),
    .waddr (rhs_waddr),
    .wdata (rhs_wdata),
    .re    (rhs_re),
    .raddr (rhs_raddr),
    .rdata (rhs_q)
  );

  ges_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_sol (
    .clk   (clk),
    .we    (sol_we),
    .waddr (i),
    .wdata (xacc),
    .re    (sol_re),
    .raddr (sol_raddr),
    .rdata (sol_q)
  );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Gaussian elimination solver testbench
// Loads matrix and right-hand-side words with random gaps, issues solves under
// several system sizes, and checks every solution word against a binary32
// predictor kept in a small scoreboard class. Covers edge sizes, opcode 3,
// repeated solves, zero pivots and raw bit patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  function automatic real f32_to_real(logic [31:0] f);
    logic [63:0] d;
    int          e;
    logic [23:0] mm;
    e  = f[30:23];
    mm = {1'b0, f[22:0]};
    if (e == 255) begin
      d = {f[31], 11'h7ff, f[22:0], 29'd0};
    end else if (e == 0) begin
      if (mm == 0) begin
        d = {f[31], 63'd0};
      end else begin
        e = -126;
        while (!mm[23]) begin
          mm = mm << 1;
          e--;
        end
        d = {f[31], 11'(e + 1023), mm[22:0], 29'd0};
      end
    end else begin
      d = {f[31], 11'(e - 127 + 1023), f[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [63:0] shift_rne(logic [63:0] sig, int sh);
    logic [63:0] q, rem, half;
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d, sig, q;
    int          e;
    logic [31:0] mag;
    d = $realtobits(r);
    if (d[62:52] == 11'h7ff) begin
      if (d[51:0] != 0) return 32'h7fc0_0000;
      return {d[63], 31'h7f80_0000};
    end
    if (d[62:52] == 0) return {d[63], 31'd0};
    e   = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    if (e > 127) return {d[63], 31'h7f80_0000};
    if (e >= -126) begin
      q   = shift_rne(sig, 29);
      mag = 32'((e + 126) << 23) + q[31:0];
      if (mag >= 32'h7f80_0000) mag = 32'h7f80_0000;
    end else begin
      if (29 + (-126 - e) > 60) return {d[63], 31'd0};
      q   = shift_rne(sig, 29 + (-126 - e));
      mag = q[31:0];
    end
    return {d[63], mag[30:0]};
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) - f32_to_real(b));
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
    return real_to_f32(f32_to_real(a) / f32_to_real(b));
  endfunction

  function automatic bit is_nan(logic [31:0] f);
    return f[30:23] == 8'hff && f[22:0] != 0;
  endfunction

  class solver_scoreboard;
    logic [31:0]   mat[256];
    logic [31:0]   rhs[16];
    logic [31:0]   sol[16];
    logic [4:0]    size_reg;
    ges_pkg::res_t pending[$];
    int            errors;
    int            solves;
    int            words_seen;

    function new();
      size_reg = ges_pkg::SIZE_RESET;
      foreach (mat[i]) mat[i] = 32'd0;
      foreach (rhs[i]) rhs[i] = 32'd0;
      foreach (sol[i]) sol[i] = 32'd0;
    endfunction

    function void set_size(logic [4:0] s);
      size_reg = s;
    endfunction

    function void note_cmd(ges_pkg::cmd_t c);
      int            n;
      logic [31:0]   coef, piv, x;
      ges_pkg::res_t r;
      case (c.opcode)
        ges_pkg::OP_LOAD_MATRIX: mat[{c.row_index, c.col_index}] = c.element_value;
        ges_pkg::OP_LOAD_RHS:    rhs[c.row_index] = c.element_value;
        ges_pkg::OP_SOLVE: begin
          n = (size_reg == 0) ? 1 : (size_reg > 16) ? 16 : size_reg;
          solves++;
          for (int i = 0; i + 1 < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
              coef   = fdiv(mat[j * 16 + i], mat[i * 16 + i]);
              rhs[j] = fsub(rhs[j], fmul(coef, rhs[i]));
              for (int k = 0; k < n; k++)
                mat[j * 16 + k] = fsub(mat[j * 16 + k], fmul(coef, mat[i * 16 + k]));
            end
          end
          for (int i = n - 1; i >= 0; i--) begin
            piv = mat[i * 16 + i];
            x   = fdiv(rhs[i], piv);
            for (int j = i + 1; j < n; j++)
              x = fsub(x, fdiv(fmul(mat[i * 16 + j], sol[j]), piv));
            sol[i] = x;
          end
          for (int i = 0; i < n; i++) begin
            r.solution_index = 4'(i);
            r.solution_value = sol[i];
            r.last           = (i + 1 == n);
            pending.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check(ges_pkg::res_t got);
      ges_pkg::res_t want;
      words_seen++;
      if (pending.size() == 0) begin
        $error("unexpected solution word index %0d value %h", got.solution_index,
               got.solution_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.solution_index !== want.solution_index) begin
        $error("solution_index expected %0d actual %0d", want.solution_index,
               got.solution_index);
        errors++;
      end
      if (got.solution_value !== want.solution_value &&
          !(is_nan(got.solution_value) && is_nan(want.solution_value))) begin
        $error("solution_value expected %h actual %h", want.solution_value,
               got.solution_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0b actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  ges_pkg::cmd_t cmd = '0;
  logic          valid;
  ges_pkg::res_t result;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [4:0]    cfg_data = '0;

  solver_scoreboard sb = new();
  int               items_sent;

  always #2 clk = ~clk;

  gauss_elimination_solver_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .valid     (valid),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && valid) sb.check(result);
  end

  task automatic send_word(logic [1:0] op, int row, int col, logic [31:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    cmd.opcode    <= op;
    cmd.row_index <= 4'(row);
    cmd.col_index <= 4'(col);
    cmd.element_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd('{op, 4'(row), 4'(col), val});
    items_sent++;
  endtask

  task automatic write_size(logic [4:0] s);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(s);
  endtask

  function automatic logic [31:0] rand_value(bit diag);
    logic [7:0] e;
    if ($urandom_range(0, 15) == 0) return $urandom();
    e = diag ? 8'($urandom_range(130, 133)) : 8'($urandom_range(120, 129));
    return {1'($urandom()), e, 23'($urandom())};
  endfunction

  task automatic load_system(int n);
    int order[$];
    int p;
    for (int i = 0; i < n * n + n; i++) order.push_back(i);
    order.shuffle();
    foreach (order[q]) begin
      p = order[q];
      if (p < n * n)
        send_word(ges_pkg::OP_LOAD_MATRIX, p / n, p % n, rand_value(p / n == p % n));
      else
        send_word(ges_pkg::OP_LOAD_RHS, p - n * n, $urandom_range(0, 15), rand_value(0));
    end
  endtask

  initial begin
    int          n;
    logic [4:0]  s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_size(5'd0);
    send_word(ges_pkg::OP_LOAD_MATRIX, 0, 0, 32'h4000_0000);
    send_word(ges_pkg::OP_LOAD_RHS, 0, 15, 32'h7f7f_ffff);
    send_word(ges_pkg::OP_SOLVE, 15, 15, 32'hffff_ffff);
    send_word(OP_UNUSED, 15, 15, 32'hffff_ffff);
    send_word(ges_pkg::OP_SOLVE, 0, 0, 32'h0000_0000);
    write_size(5'd2);
    send_word(ges_pkg::OP_LOAD_MATRIX, 0, 0, 32'h0000_0000);
    send_word(ges_pkg::OP_LOAD_MATRIX, 0, 1, 32'h3f80_0000);
    send_word(ges_pkg::OP_LOAD_MATRIX, 1, 0, 32'h3f80_0000);
    send_word(ges_pkg::OP_LOAD_MATRIX, 1, 1, 32'h0000_0001);
    send_word(ges_pkg::OP_LOAD_RHS, 0, 0, 32'h8000_0000);
    send_word(ges_pkg::OP_LOAD_RHS, 1, 0, 32'hff7f_ffff);
    send_word(ges_pkg::OP_SOLVE, 0, 0, 32'h0);
    write_size(5'd31);
    load_system(16);
    send_word(ges_pkg::OP_SOLVE, 9, 6, $urandom());

    while (items_sent < 350) begin
      s = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(6, 8)) : 5'($urandom_range(1, 5));
      write_size(s);
      n = s;
      repeat ($urandom_range(1, 3)) begin
        load_system(n);
        send_word(ges_pkg::OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom());
        if ($urandom_range(0, 4) == 0)
          send_word(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
        if ($urandom_range(0, 5) == 0)
          send_word(ges_pkg::OP_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom());
      end
    end
    write_size(5'd1);
    send_word(ges_pkg::OP_LOAD_MATRIX, 0, 0, rand_value(1));
    send_word(ges_pkg::OP_LOAD_RHS, 0, 3, rand_value(0));
    send_word(ges_pkg::OP_SOLVE, 0, 0, 32'h0);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d command words, %0d solves, %0d solution words checked.",
             items_sent, sb.solves, sb.words_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timeout waiting for solution words.");
    $display("Simulation FAILED");
    $finish;
  end
endmodule
